### rtl/saht_pkg.sv
// ----------------------------------------------------------------------------
// saht_pkg: shared types for the set-associative hash table unit
// Entry and bucket row layout, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package saht_pkg;

   // ways per bucket
   localparam int unsigned WAYS      = 3;
   localparam int unsigned WAY_BITS  = 2;
   localparam int unsigned TAG_BITS  = 16;
   localparam int unsigned GEN_BITS  = 6;
   // tag is taken from key bits 63..48
   localparam int unsigned TAG_LSB   = 48;

   // one stored entry (tag/move word plus data word)
   typedef struct packed {
      logic        [TAG_BITS-1:0] tag;
      logic        [15:0]         move;
      logic signed [7:0]          depth;
      logic        [GEN_BITS-1:0] age;
      logic        [1:0]          bound;
      logic signed [15:0]         static_val;
      logic signed [15:0]         value;
   } entry_type;

   // one bucket: all ways side by side
   typedef entry_type [WAYS-1:0] row_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic write_back;
      logic load_rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic is_store;
   } status_type;

endpackage

### rtl/saht_ctrl.sv
// ----------------------------------------------------------------------------
// saht_ctrl: sequencing controller
// Runs the clearing pass after reset, then one read / evaluate-or-write
// sequence per word, and owns the response valid flag.
// ----------------------------------------------------------------------------
module saht_ctrl
   import saht_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and response flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.is_store) begin
               cmd.write_back = 1'b1;
               state_in       = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               // output register free or draining this cycle
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/saht_datapath.sv
// ----------------------------------------------------------------------------
// saht_datapath: bucket memory, probe selection and store merge
// One row per bucket holds all ways; a word reads its row, then either
// picks a way for the response or writes the merged row back.
// ----------------------------------------------------------------------------
module saht_datapath
   import saht_pkg::*;
#(
   parameter int unsigned BUCKET_BITS = 10
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic                     csr_write_enable,
   input  logic [GEN_BITS-1:0]      csr_write_data,
   input  logic                     req_kind,
   input  logic [63:0]              req_key,
   input  logic [WAY_BITS-1:0]      req_way,
   input  logic [15:0]              req_best_move,
   input  logic signed [7:0]        req_search_depth,
   input  logic signed [15:0]       req_score,
   input  logic signed [15:0]       req_static_score,
   input  logic [1:0]               req_bound,
   output logic                     rsp_hit,
   output logic [WAY_BITS-1:0]      rsp_chosen_way,
   output logic [15:0]              rsp_entry_move,
   output logic signed [7:0]        rsp_entry_depth,
   output logic [1:0]               rsp_entry_bound,
   output logic [GEN_BITS-1:0]      rsp_entry_age,
   output logic signed [15:0]       rsp_entry_static,
   output logic signed [15:0]       rsp_entry_value
);

   localparam int unsigned NUM_ROWS = 1 << BUCKET_BITS;

   row_type mem [NUM_ROWS];

   logic [GEN_BITS-1:0]    gen_ff;
   logic [BUCKET_BITS-1:0] clr_cnt_ff;
   logic [BUCKET_BITS-1:0] bucket_ff;
   logic [TAG_BITS-1:0]    tag_ff;
   logic                   kind_ff;
   logic [WAY_BITS-1:0]    way_ff;
   logic [15:0]            move_ff;
   logic signed [7:0]      depth_ff;
   logic signed [15:0]     score_ff;
   logic signed [15:0]     static_ff;
   logic [1:0]             bound_ff;
   row_type                rd_row_ff;

   row_type                row_new;
   logic [WAY_BITS-1:0]    pick;
   logic                   hit;
   logic                   found;
   logic signed [9:0]      metric [WAYS];
   logic signed [9:0]      best;
   entry_type              old_e;
   entry_type              new_e;
   entry_type              sel_e;

   // search generation register
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= '0;
      end else if (csr_write_enable) begin
         gen_ff <= csr_write_data;
      end
   end

   // clearing pass row counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign status.clear_last = &clr_cnt_ff;
   assign status.is_store   = kind_ff;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff   <= req_kind;
         bucket_ff <= req_key[BUCKET_BITS-1:0];
         tag_ff    <= req_key[TAG_LSB +: TAG_BITS];
         way_ff    <= req_way;
         move_ff   <= req_best_move;
         depth_ff  <= req_search_depth;
         score_ff  <= req_score;
         static_ff <= req_static_score;
         bound_ff  <= req_bound;
      end
   end

   // bucket memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (cmd.clear_wr) begin
         mem[clr_cnt_ff] <= '0;
      end else if (cmd.write_back) begin
         mem[bucket_ff] <= row_new;
      end
      if (cmd.accept) begin
         rd_row_ff <= mem[req_key[BUCKET_BITS-1:0]];
      end
   end

   // store merge into the addressed way (way 3 leaves the row unchanged)
   always_comb begin
      row_new = rd_row_ff;
      old_e   = rd_row_ff[0];
      new_e   = rd_row_ff[0];
      for (int i = 0; i < WAYS; i++) begin
         if (way_ff == WAY_BITS'(i)) begin
            old_e = rd_row_ff[i];
            new_e = rd_row_ff[i];
            if (move_ff != '0 || tag_ff != old_e.tag) begin
               new_e.move = move_ff;
            end
            if (tag_ff != old_e.tag || depth_ff > old_e.depth) begin
               new_e.tag        = tag_ff;
               new_e.depth      = depth_ff;
               new_e.age        = gen_ff;
               new_e.bound      = bound_ff;
               new_e.static_val = static_ff;
               new_e.value      = score_ff;
            end
            row_new[i] = new_e;
         end
      end
   end

   // replacement metric: depth - (generation - age)
   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         metric[i] = {{2{rd_row_ff[i].depth[7]}}, rd_row_ff[i].depth}
                   + {4'b0, rd_row_ff[i].age} - {4'b0, gen_ff};
      end
   end

   // probe: first way whose tag matches (a hit) or is empty, else lowest metric
   always_comb begin
      pick  = '0;
      hit   = 1'b0;
      found = 1'b0;
      best  = metric[0];
      for (int i = 0; i < WAYS; i++) begin
         if (!found) begin
            if (rd_row_ff[i].tag == tag_ff) begin
               pick  = WAY_BITS'(i);
               hit   = 1'b1;
               found = 1'b1;
            end else if (rd_row_ff[i].tag == '0) begin
               pick  = WAY_BITS'(i);
               found = 1'b1;
            end
         end
      end
      if (!found) begin
         for (int i = 1; i < WAYS; i++) begin
            if (metric[i] < best) begin
               best = metric[i];
               pick = WAY_BITS'(i);
            end
         end
      end
      sel_e = rd_row_ff[pick];
   end

   // response output register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_hit          <= hit;
         rsp_chosen_way   <= pick;
         rsp_entry_move   <= sel_e.move;
         rsp_entry_depth  <= sel_e.depth;
         rsp_entry_bound  <= sel_e.bound;
         rsp_entry_age    <= sel_e.age;
         rsp_entry_static <= sel_e.static_val;
         rsp_entry_value  <= sel_e.value;
      end
   end

endmodule

### rtl/set_assoc_hash_table_probe_store_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_hash_table_probe_store_unit: 3-way hash table probe/store
//
//   channel | direction | handshake            | words
//   req_    | in        | req_valid/req_ready  | probe or store request
//   rsp_    | out       | rsp_valid/rsp_ready  | one per probe, none per store
//   csr_    | in        | csr_write_enable     | search generation
//
// Each word is a bucket row read, then either the probe result
// is registered or the merged row is written back on the single memory port.
// After reset a clearing pass zeroes all 2**BUCKET_BITS bucket rows, one per cycle,
// with req_ready low; csr writes are taken throughout.
// A probe whose response is still held stalls until the output register frees.
// ----------------------------------------------------------------------------
module set_assoc_hash_table_probe_store_unit
   import saht_pkg::*;
#(
   parameter int unsigned BUCKET_BITS = 10
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [GEN_BITS-1:0]  csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [63:0]          req_key,
   input  logic [WAY_BITS-1:0]  req_way,
   input  logic [15:0]          req_best_move,
   input  logic signed [7:0]    req_search_depth,
   input  logic signed [15:0]   req_score,
   input  logic signed [15:0]   req_static_score,
   input  logic [1:0]           req_bound,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_hit,
   output logic [WAY_BITS-1:0]  rsp_chosen_way,
   output logic [15:0]          rsp_entry_move,
   output logic signed [7:0]    rsp_entry_depth,
   output logic [1:0]           rsp_entry_bound,
   output logic [GEN_BITS-1:0]  rsp_entry_age,
   output logic signed [15:0]   rsp_entry_static,
   output logic signed [15:0]   rsp_entry_value
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   saht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // table and selection logic
   saht_datapath #(
      .BUCKET_BITS (BUCKET_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_kind         (req_kind),
      .req_key          (req_key),
      .req_way          (req_way),
      .req_best_move    (req_best_move),
      .req_search_depth (req_search_depth),
      .req_score        (req_score),
      .req_static_score (req_static_score),
      .req_bound        (req_bound),
      .rsp_hit          (rsp_hit),
      .rsp_chosen_way   (rsp_chosen_way),
      .rsp_entry_move   (rsp_entry_move),
      .rsp_entry_depth  (rsp_entry_depth),
      .rsp_entry_bound  (rsp_entry_bound),
      .rsp_entry_age    (rsp_entry_age),
      .rsp_entry_static (rsp_entry_static),
      .rsp_entry_value  (rsp_entry_value)
   );

endmodule

### sim/hash_table_checker.sv
// ----------------------------------------------------------------------------
// hash_table_checker: probe/store prediction and response compare
// Keeps its own copy of the 3-way table and the search generation, follows
// every accepted request word, and compares each response word field by
// field against the oldest predicted probe result.
// ----------------------------------------------------------------------------
module hash_table_checker
   import saht_pkg::*;
#(
   parameter int unsigned BUCKET_BITS = 10
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [GEN_BITS-1:0]  csr_write_data,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_kind,
   input  logic [63:0]          req_key,
   input  logic [WAY_BITS-1:0]  req_way,
   input  logic [15:0]          req_best_move,
   input  logic signed [7:0]    req_search_depth,
   input  logic signed [15:0]   req_score,
   input  logic signed [15:0]   req_static_score,
   input  logic [1:0]           req_bound,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic                 rsp_hit,
   input  logic [WAY_BITS-1:0]  rsp_chosen_way,
   input  logic [15:0]          rsp_entry_move,
   input  logic signed [7:0]    rsp_entry_depth,
   input  logic [1:0]           rsp_entry_bound,
   input  logic [GEN_BITS-1:0]  rsp_entry_age,
   input  logic signed [15:0]   rsp_entry_static,
   input  logic signed [15:0]   rsp_entry_value,
   output int                   mismatch_count,
   output int                   probes_pending
);

   localparam int unsigned ENTRIES = (1 << BUCKET_BITS) * WAYS;

   typedef struct packed {
      logic                 hit;
      logic [WAY_BITS-1:0]  way;
      logic [15:0]          move;
      logic signed [7:0]    depth;
      logic [1:0]           bound;
      logic [GEN_BITS-1:0]  age;
      logic signed [15:0]   static_val;
      logic signed [15:0]   value;
   } probe_word_type;

   entry_type           table_copy [ENTRIES];
   logic [GEN_BITS-1:0] search_gen;
   probe_word_type      expected_probes [$];
   probe_word_type      oldest;

   // replacement rank: depth minus how many generations old the entry is
   function automatic int replace_rank(input entry_type e);
      return int'(e.depth) - (int'(search_gen) - int'(e.age));
   endfunction

   function automatic probe_word_type predict_probe(input logic [63:0] key);
      int             base;
      int             pick;
      int             best;
      int             rank_now;
      logic [TAG_BITS-1:0] tag;
      bit             found;
      bit             hit;
      entry_type      e;
      probe_word_type r;
      base  = int'(key[BUCKET_BITS-1:0]) * WAYS;
      tag   = key[TAG_LSB +: TAG_BITS];
      pick  = 0;
      found = 0;
      hit   = 0;
      // first way whose tag matches or that is empty
      for (int i = 0; i < WAYS; i++) begin
         if (!found && table_copy[base+i].tag == tag) begin
            pick  = i;
            hit   = 1;
            found = 1;
         end else if (!found && table_copy[base+i].tag == '0) begin
            pick  = i;
            found = 1;
         end
      end
      // full bucket: lowest rank, ties keep the lower way
      if (!found) begin
         best = replace_rank(table_copy[base]);
         for (int i = 1; i < WAYS; i++) begin
            rank_now = replace_rank(table_copy[base+i]);
            if (rank_now < best) begin
               best = rank_now;
               pick = i;
            end
         end
      end
      e            = table_copy[base+pick];
      r.hit        = hit;
      r.way        = pick[WAY_BITS-1:0];
      r.move       = e.move;
      r.depth      = e.depth;
      r.bound      = e.bound;
      r.age        = e.age;
      r.static_val = e.static_val;
      r.value      = e.value;
      return r;
   endfunction

   function automatic void apply_store(input logic [63:0] key,
                                       input logic [WAY_BITS-1:0] way,
                                       input logic [15:0] move,
                                       input logic signed [7:0] depth,
                                       input logic signed [15:0] score,
                                       input logic signed [15:0] static_score,
                                       input logic [1:0] bound);
      int                  slot;
      logic [TAG_BITS-1:0] tag;
      logic                tag_differs;
      // way 3 does not exist: the word is dropped
      if (way >= WAYS) return;
      slot        = int'(key[BUCKET_BITS-1:0]) * WAYS + int'(way);
      tag         = key[TAG_LSB +: TAG_BITS];
      tag_differs = table_copy[slot].tag != tag;
      if (move != '0 || tag_differs) table_copy[slot].move = move;
      if (tag_differs || depth > table_copy[slot].depth) begin
         table_copy[slot].tag        = tag;
         table_copy[slot].depth      = depth;
         table_copy[slot].age        = search_gen;
         table_copy[slot].bound      = bound;
         table_copy[slot].static_val = static_score;
         table_copy[slot].value      = score;
      end
   endfunction

   function automatic void compare_field(input string field_name,
                                         input int expected_value,
                                         input int actual_value);
      if (expected_value !== actual_value) begin
         mismatch_count++;
         $error("%s: expected %0d, got %0d", field_name, expected_value, actual_value);
      end
   endfunction

   // responses are checked before new requests are queued
   always @(posedge clock) begin
      if (reset) begin
         foreach (table_copy[i]) table_copy[i] = '0;
         search_gen = '0;
         expected_probes.delete();
      end else begin
         if (csr_write_enable) search_gen = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_probes.size() == 0) begin
               mismatch_count++;
               $error("response word with no probe outstanding");
            end else begin
               oldest = expected_probes.pop_front();
               compare_field("hit", int'(oldest.hit), int'(rsp_hit));
               compare_field("chosen_way", int'(oldest.way), int'(rsp_chosen_way));
               compare_field("entry_move", int'(oldest.move), int'(rsp_entry_move));
               compare_field("entry_depth", int'(oldest.depth), int'(rsp_entry_depth));
               compare_field("entry_bound", int'(oldest.bound), int'(rsp_entry_bound));
               compare_field("entry_age", int'(oldest.age), int'(rsp_entry_age));
               compare_field("entry_static", int'(oldest.static_val),
                             int'(rsp_entry_static));
               compare_field("entry_value", int'(oldest.value), int'(rsp_entry_value));
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind)
               apply_store(req_key, req_way, req_best_move, req_search_depth,
                           req_score, req_static_score, req_bound);
            else
               expected_probes.push_back(predict_probe(req_key));
         end
      end
      probes_pending = expected_probes.size();
   end

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb: regression for the 3-way hash table probe/store unit
// Drives a directed opening (empty ways, zero tag, dropped way-3 stores,
// move-only updates, replacement ties and aging), then phases of random
// probe/store pairs over a few hot buckets at several search generations,
// with random gaps on both channels in all phases but one. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
   import saht_pkg::*;

   localparam int unsigned BUCKET_BITS = 10;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PHASES      = 6;
   localparam int          PHASE_WORDS = 300;

   localparam logic REQ_PROBE = 1'b0;
   localparam logic REQ_STORE = 1'b1;
   localparam logic [WAY_BITS-1:0] NO_WAY = 2'd3;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [GEN_BITS-1:0]  csr_write_data;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_kind;
   logic [63:0]          req_key;
   logic [WAY_BITS-1:0]  req_way;
   logic [15:0]          req_best_move;
   logic signed [7:0]    req_search_depth;
   logic signed [15:0]   req_score;
   logic signed [15:0]   req_static_score;
   logic [1:0]           req_bound;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_hit;
   logic [WAY_BITS-1:0]  rsp_chosen_way;
   logic [15:0]          rsp_entry_move;
   logic signed [7:0]    rsp_entry_depth;
   logic [1:0]           rsp_entry_bound;
   logic [GEN_BITS-1:0]  rsp_entry_age;
   logic signed [15:0]   rsp_entry_static;
   logic signed [15:0]   rsp_entry_value;

   int mismatch_count;
   int probes_pending;
   int cycle_count = 0;
   int stall_left  = 0;
   bit gaps_on     = 0;

   set_assoc_hash_table_probe_store_unit #(.BUCKET_BITS(BUCKET_BITS)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_key          (req_key),
      .req_way          (req_way),
      .req_best_move    (req_best_move),
      .req_search_depth (req_search_depth),
      .req_score        (req_score),
      .req_static_score (req_static_score),
      .req_bound        (req_bound),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_chosen_way   (rsp_chosen_way),
      .rsp_entry_move   (rsp_entry_move),
      .rsp_entry_depth  (rsp_entry_depth),
      .rsp_entry_bound  (rsp_entry_bound),
      .rsp_entry_age    (rsp_entry_age),
      .rsp_entry_static (rsp_entry_static),
      .rsp_entry_value  (rsp_entry_value)
   );

   hash_table_checker #(.BUCKET_BITS(BUCKET_BITS)) table_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_key          (req_key),
      .req_way          (req_way),
      .req_best_move    (req_best_move),
      .req_search_depth (req_search_depth),
      .req_score        (req_score),
      .req_static_score (req_static_score),
      .req_bound        (req_bound),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_chosen_way   (rsp_chosen_way),
      .rsp_entry_move   (rsp_entry_move),
      .rsp_entry_depth  (rsp_entry_depth),
      .rsp_entry_bound  (rsp_entry_bound),
      .rsp_entry_age    (rsp_entry_age),
      .rsp_entry_static (rsp_entry_static),
      .rsp_entry_value  (rsp_entry_value),
      .mismatch_count   (mismatch_count),
      .probes_pending   (probes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("set_assoc_hash_table_probe_store_unit regression: fail");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   // response side back-pressure
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!gaps_on) stall_left = 0;
         else if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = gap_length();
         rsp_ready <= (stall_left == 0);
         if (stall_left > 0) stall_left--;
      end
   end

   function automatic logic [63:0] make_key(input logic [TAG_BITS-1:0] tag,
                                            input logic [BUCKET_BITS-1:0] bucket);
      logic [63:0] key;
      key = {$urandom, $urandom};
      key[TAG_LSB +: TAG_BITS] = tag;
      key[BUCKET_BITS-1:0] = bucket;
      return key;
   endfunction

   // hot buckets and few tags so buckets fill, hit and get replaced
   function automatic logic [63:0] pick_key();
      logic [TAG_BITS-1:0]    tag;
      logic [BUCKET_BITS-1:0] bucket;
      case ($urandom_range(0, 9))
         0:       tag = '1;
         1, 2:    tag = TAG_BITS'($urandom);
         default: tag = TAG_BITS'($urandom_range(0, 5));
      endcase
      case ($urandom_range(0, 9))
         0:       bucket = '0;
         1:       bucket = '1;
         2:       bucket = BUCKET_BITS'(1 << (BUCKET_BITS - 1));
         3, 4:    bucket = BUCKET_BITS'($urandom);
         default: bucket = BUCKET_BITS'($urandom_range(1, 3));
      endcase
      return make_key(tag, bucket);
   endfunction

   task automatic send_word(input logic kind, input logic [63:0] key,
                            input logic [WAY_BITS-1:0] way, input logic [15:0] move,
                            input logic signed [7:0] depth, input logic signed [15:0] score,
                            input logic signed [15:0] static_score, input logic [1:0] bound);
      int gap;
      gap = gaps_on ? gap_length() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_key          <= key;
      req_way          <= way;
      req_best_move    <= move;
      req_search_depth <= depth;
      req_score        <= score;
      req_static_score <= static_score;
      req_bound        <= bound;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // unused fields of a probe still toggle
   task automatic probe(input logic [63:0] key);
      send_word(REQ_PROBE, key, WAY_BITS'($urandom), 16'($urandom), 8'($urandom),
                16'($urandom), 16'($urandom), 2'($urandom));
   endtask

   task automatic store(input logic [63:0] key, input logic [WAY_BITS-1:0] way,
                        input logic [15:0] move, input logic signed [7:0] depth,
                        input logic signed [15:0] score, input logic signed [15:0] static_score,
                        input logic [1:0] bound);
      send_word(REQ_STORE, key, way, move, depth, score, static_score, bound);
   endtask

   // let every probe come back and the last store retire
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (probes_pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_generation(input logic [GEN_BITS-1:0] gen);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= gen;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic random_phase(input int word_count);
      logic [63:0]         key;
      logic [WAY_BITS-1:0] way;
      logic [15:0]         move;
      logic signed [7:0]   depth;
      int                  n;
      n = 0;
      while (n < word_count) begin
         key = pick_key();
         if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
         // probe, then usually a store to the same key
         probe(key);
         n++;
         if ($urandom_range(0, 4) != 0) begin
            way   = ($urandom_range(0, 15) == 0) ? NO_WAY
                                                 : WAY_BITS'($urandom_range(0, WAYS - 1));
            move  = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
            depth = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 6)) - 8'sd3
                                                : 8'($urandom);
            store(key, way, move, depth, 16'($urandom), 16'($urandom), 2'($urandom));
            n++;
         end
      end
   endtask

   logic [63:0] all_ones_key;

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_kind         = REQ_PROBE;
      req_key          = '0;
      req_way          = '0;
      req_best_move    = '0;
      req_search_depth = '0;
      req_score        = '0;
      req_static_score = '0;
      req_bound        = '0;
      all_ones_key     = '1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // generation can be written during the clearing pass
      write_generation('0);

      // zero tag against an empty bucket, then a miss on the top bucket
      probe('0);
      probe(all_ones_key);
      store(all_ones_key, 2'd0, 16'hFFFF, 8'sd127, 16'sh7FFF, 16'sh8000, 2'd3);
      probe(all_ones_key);
      // way 3 store is dropped; same tag, no move, no deeper: no change
      store(all_ones_key, NO_WAY, 16'h0001, 8'sd0, 16'sd1, 16'sd1, 2'd0);
      store(all_ones_key, 2'd0, 16'h0000, -8'sd128, 16'sd5, 16'sd5, 2'd1);
      // same tag, new move, not deeper: move only
      store(all_ones_key, 2'd0, 16'h1234, 8'sd127, 16'sd9, 16'sd9, 2'd2);
      probe(all_ones_key);
      // fill the top bucket, then force a replacement pick
      store(make_key(16'h1111, '1), 2'd1, 16'h0000, -8'sd128, -16'sd1, 16'sd2, 2'd1);
      store(make_key(16'h2222, '1), 2'd2, 16'h00AA, 8'sd0, 16'sd3, -16'sd4, 2'd2);
      probe(make_key(16'h3333, '1));
      store(make_key(16'h2222, '1), 2'd2, 16'h0000, 8'sd1, 16'sd7, 16'sd8, 2'd3);
      probe(make_key(16'h2222, '1));
      // equal ranks in bucket 5: lowest way wins
      store(make_key(16'h000A, BUCKET_BITS'(5)), 2'd0, 16'h0A0A, 8'sd10, 16'sd1, 16'sd1, 2'd0);
      store(make_key(16'h000B, BUCKET_BITS'(5)), 2'd1, 16'h0B0B, 8'sd10, 16'sd2, 16'sd2, 2'd1);
      store(make_key(16'h000C, BUCKET_BITS'(5)), 2'd2, 16'h0C0C, 8'sd10, 16'sd3, 16'sd3, 2'd2);
      probe(make_key(16'h000D, BUCKET_BITS'(5)));
      drain();

      // top generation: old entries rank lower
      write_generation('1);
      probe(make_key(16'h000D, BUCKET_BITS'(5)));
      store(make_key(16'h000E, BUCKET_BITS'(5)), 2'd2, 16'h0E0E, 8'sd10, 16'sd4, 16'sd4, 2'd3);
      probe(make_key(16'h000D, BUCKET_BITS'(5)));
      probe(make_key(16'h000E, BUCKET_BITS'(5)));
      // zero tag matches the empty way and may be deepened
      store('0, 2'd0, 16'h0000, 8'sd5, 16'sd11, 16'sd12, 2'd1);
      probe('0);
      drain();

      // random phases at several generations, one phase without gaps
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       write_generation('1);
            1:       write_generation('0);
            2:       write_generation(6'd1);
            default: write_generation(GEN_BITS'($urandom_range(0, 63)));
         endcase
         gaps_on = (p != 2);
         random_phase(PHASE_WORDS);
         drain();
      end

      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("set_assoc_hash_table_probe_store_unit regression: pass");
      else
         $display("set_assoc_hash_table_probe_store_unit regression: fail");
      $finish;
   end

endmodule

### filelist.f
rtl/saht_pkg.sv
rtl/saht_ctrl.sv
rtl/saht_datapath.sv
rtl/set_assoc_hash_table_probe_store_unit.sv
sim/hash_table_checker.sv
sim/tb.sv
